// ===== rtl/rwhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhc_pkg - shared types and constants of the RIFF/WAVE header checker
// Parse phases, status codes, tag words and the result record.
// ----------------------------------------------------------------------------
package rwhc_pkg;

	// Chunk and file tags as they appear in the byte stream, first byte highest
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FMT_MIN_BYTES = 32'd16;

	// Reset values of the rate limit registers
	localparam logic [31:0] MIN_RATE_RESET = 32'd8000;
	localparam logic [31:0] MAX_RATE_RESET = 32'd192000;

	// Configuration register indexes
	localparam logic CFG_MIN_RATE = 1'b0;
	localparam logic CFG_MAX_RATE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_HEADER  = 2'd1,
		ST_SHORT_CHUNK = 2'd2,
		ST_BAD_FORMAT  = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		PH_FILE_HDR  = 7'b000_0001,
		PH_BAD_HDR   = 7'b000_0010,
		PH_CHUNK_HDR = 7'b000_0100,
		PH_FMT_BODY  = 7'b000_1000,
		PH_SKIP      = 7'b001_0000,
		PH_STOPPED   = 7'b010_0000,
		PH_IGNORE    = 7'b100_0000
	} phase_t;

	typedef struct packed {
		logic        accepted;
		status_t     status;
		logic [15:0] wave_format;
		logic [15:0] channels;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
	} result_t;

endpackage

// ===== rtl/rwhc_judge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhc_judge - format check at the data chunk header
// Grades the held fmt values and the data size against the rate limits.
// ----------------------------------------------------------------------------
module rwhc_judge
	import rwhc_pkg::*;
(
	input  logic        fmt_seen,
	input  logic [15:0] wave_format,
	input  logic [15:0] channels,
	input  logic [31:0] rate_hz,
	input  logic [15:0] sample_bits,
	input  logic [31:0] data_size,
	input  logic [31:0] rate_min,
	input  logic [31:0] rate_max,
	output status_t     status
);

	logic chan_ok;
	logic bits_ok;
	logic rate_ok;

	assign chan_ok = (channels == 16'd1) || (channels == 16'd2);
	assign bits_ok = (sample_bits == 16'd8) || (sample_bits == 16'd16);
	assign rate_ok = (rate_hz >= rate_min) && (rate_hz <= rate_max);

	// Missing fmt or empty data first, then the format itself
	always_comb begin
		if (!fmt_seen || (data_size == 32'd0)) begin
			status = ST_SHORT_CHUNK;
		end else if ((wave_format != 16'd1) || !chan_ok || !bits_ok || !rate_ok) begin
			status = ST_BAD_FORMAT;
		end else begin
			status = ST_OK;
		end
	end

endmodule

// ===== rtl/rwhc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhc_parser - byte-wise RIFF/WAVE chunk walker
// Holds the parse state and forms at most one result per accepted byte.
// ----------------------------------------------------------------------------
module rwhc_parser
	import rwhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [31:0] rate_min,
	input  logic [31:0] rate_max,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q,  phase_d;
	logic [3:0]  pos_q,    pos_d;
	logic [63:0] shift_q,  shift_d;
	logic [31:0] left_q,   left_d;
	logic        pad_q,    pad_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic [15:0] tag_q,    tag_d;
	logic [15:0] chan_q,   chan_d;
	logic [31:0] rate_q,   rate_d;
	logic [15:0] bits_q,   bits_d;
	logic        given_q,  given_d;

	logic [63:0] shift_new;
	logic [31:0] chunk_size;
	logic [31:0] left_dec;
	status_t     judge_status;
	logic        hit;

	assign shift_new  = {shift_q[55:0], data_byte};
	assign chunk_size = {shift_new[7:0], shift_new[15:8], shift_new[23:16], shift_new[31:24]};
	assign left_dec   = (left_q != 32'd0) ? (left_q - 32'd1) : left_q;

	rwhc_judge u_judge (
		.fmt_seen    (fmt_seen_q),
		.wave_format (tag_q),
		.channels    (chan_q),
		.rate_hz     (rate_q),
		.sample_bits (bits_q),
		.data_size   (chunk_size),
		.rate_min    (rate_min),
		.rate_max    (rate_max),
		.status      (judge_status)
	);

	// Next parse state and result for the byte on the input
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		shift_d    = shift_q;
		left_d     = left_q;
		pad_d      = pad_q;
		fmt_seen_d = fmt_seen_q;
		tag_d      = tag_q;
		chan_d     = chan_q;
		rate_d     = rate_q;
		bits_d     = bits_q;
		given_d    = given_q;
		hit        = 1'b0;
		res        = '0;

		case (phase_q)
			PH_FILE_HDR: begin
				shift_d = shift_new;
				if ((pos_q == 4'd3) && (shift_new[31:0] != TAG_RIFF)) begin
					phase_d = PH_BAD_HDR;
				end else if (pos_q >= 4'd11) begin
					if (shift_new[31:0] != TAG_WAVE) begin
						phase_d = PH_BAD_HDR;
					end else begin
						phase_d = PH_CHUNK_HDR;
						pos_d   = 4'd0;
					end
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_CHUNK_HDR: begin
				shift_d = shift_new;
				if (pos_q >= 4'd7) begin
					pos_d  = 4'd0;
					left_d = chunk_size;
					pad_d  = chunk_size[0];
					if (shift_new[63:32] == TAG_DATA) begin
						hit           = 1'b1;
						res.status    = judge_status;
						res.data_size = chunk_size;
						given_d       = 1'b1;
						phase_d       = PH_IGNORE;
					end else if (shift_new[63:32] == TAG_FMT) begin
						if (chunk_size < FMT_MIN_BYTES) begin
							phase_d = PH_STOPPED;
						end else begin
							fmt_seen_d = 1'b0;
							phase_d    = PH_FMT_BODY;
						end
					end else if (chunk_size == 32'd0) begin
						phase_d = PH_CHUNK_HDR;
					end else begin
						phase_d = PH_SKIP;
					end
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_FMT_BODY: begin
				case (pos_q)
					4'd0:    tag_d[7:0]    = data_byte;
					4'd1:    tag_d[15:8]   = data_byte;
					4'd2:    chan_d[7:0]   = data_byte;
					4'd3:    chan_d[15:8]  = data_byte;
					4'd4:    rate_d[7:0]   = data_byte;
					4'd5:    rate_d[15:8]  = data_byte;
					4'd6:    rate_d[23:16] = data_byte;
					4'd7:    rate_d[31:24] = data_byte;
					4'd14:   bits_d[7:0]   = data_byte;
					4'd15:   bits_d[15:8]  = data_byte;
					default: ;
				endcase
				left_d = left_dec;
				if (pos_q == 4'd15) begin
					fmt_seen_d = 1'b1;
					pos_d      = 4'd0;
					if ((left_dec == 32'd0) && !pad_q) begin
						phase_d = PH_CHUNK_HDR;
					end else begin
						phase_d = PH_SKIP;
					end
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_SKIP: begin
				// Body bytes first, then the pad byte of an odd chunk
				if (left_q != 32'd0) begin
					left_d = left_q - 32'd1;
					if ((left_q == 32'd1) && !pad_q) begin
						phase_d = PH_CHUNK_HDR;
						pos_d   = 4'd0;
					end
				end else begin
					pad_d   = 1'b0;
					phase_d = PH_CHUNK_HDR;
					pos_d   = 4'd0;
				end
			end
			default: ;
		endcase

		// Failure result at the end of a file that gave none
		if (last_byte && !hit && !given_q) begin
			hit = 1'b1;
			if ((phase_d == PH_FILE_HDR) || (phase_d == PH_BAD_HDR)) begin
				res.status = ST_BAD_HEADER;
			end else begin
				res.status = ST_SHORT_CHUNK;
			end
			res.data_size = 32'd0;
		end

		res.accepted    = (res.status == ST_OK);
		res.wave_format = tag_d;
		res.channels    = chan_d;
		res.rate_hz     = rate_d;
		res.sample_bits = bits_d;

		// Restart for the next file
		if (last_byte) begin
			phase_d    = PH_FILE_HDR;
			pos_d      = 4'd0;
			shift_d    = '0;
			left_d     = '0;
			pad_d      = 1'b0;
			fmt_seen_d = 1'b0;
			tag_d      = '0;
			chan_d     = '0;
			rate_d     = '0;
			bits_d     = '0;
			given_d    = 1'b0;
		end
	end

	assign res_valid = take && hit;

	// Advance the parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FILE_HDR;
			pos_q      <= '0;
			shift_q    <= '0;
			left_q     <= '0;
			pad_q      <= 1'b0;
			fmt_seen_q <= 1'b0;
			tag_q      <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
			given_q    <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			shift_q    <= shift_d;
			left_q     <= left_d;
			pad_q      <= pad_d;
			fmt_seen_q <= fmt_seen_d;
			tag_q      <= tag_d;
			chan_q     <= chan_d;
			rate_q     <= rate_d;
			bits_q     <= bits_d;
			given_q    <= given_d;
		end
	end

`ifndef SYNTHESIS
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> (phase_q == PH_FILE_HDR) && !given_q)
		else $error("parser did not restart after the last byte");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !given_q)
		else $error("second result for one file");
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FILE_HDR) |-> (pos_q <= 4'd11))
		else $error("file header position out of range");
`endif

endmodule

// ===== rtl/rwhc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhc_out_reg - result output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rwhc_out_reg
	import rwhc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_stall,
	output logic    busy,
	output logic    out_valid,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;
	logic    drain;

	assign drain     = valid_q && !out_stall;
	assign busy      = valid_q && out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	// Hold the request flag until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || drain)
		else $error("pending result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !drain && !load |=> valid_q && $stable(res_q))
		else $error("waiting result changed");
`endif

endmodule

// ===== rtl/riff_wave_header_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_header_checker - RIFF/WAVE header check on a byte stream
// Walks the chunks of a WAV file and grades its fmt chunk, one result a file.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle: each byte passes through the parse
// state registers, so a new request is taken every clock as long as no result
// is waiting stalled in the output register. One result per file appears in
// the cycle after the data chunk header completes, or after the byte flagged
// last_byte if none was given; bytes after a result are dropped until
// last_byte restarts the parser. The user writes the rate limits through the
// configuration port only while no file is in flight, unchecked by the block.
module riff_wave_header_checker
	import rwhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [1:0]  status,
	output logic [15:0] wave_format,
	output logic [15:0] channels,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_bits,
	output logic [31:0] data_size
);

	logic [31:0] min_rate_q;
	logic [31:0] max_rate_q;
	logic        take;
	logic        res_valid;
	logic        busy;
	result_t     res;
	result_t     res_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= MIN_RATE_RESET;
			max_rate_q <= MAX_RATE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MIN_RATE: min_rate_q <= cfg_data;
				CFG_MAX_RATE: max_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stall input only while a result waits stalled
	assign in_stall = busy;
	assign take     = in_valid && !in_stall;

	rwhc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rate_min  (min_rate_q),
		.rate_max  (max_rate_q),
		.res_valid (res_valid),
		.res       (res)
	);

	rwhc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_in    (res),
		.out_stall (out_stall),
		.busy      (busy),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign accepted    = res_out.accepted;
	assign status      = res_out.status;
	assign wave_format = res_out.wave_format;
	assign channels    = res_out.channels;
	assign rate_hz     = res_out.rate_hz;
	assign sample_bits = res_out.sample_bits;
	assign data_size   = res_out.data_size;

endmodule
